### hdl/wfha_pkg.sv
// ----------------------------------------------------------------------------
// Worst-fit heap allocator package
// Shared types for the sequencer and its datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wfha_pkg;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_ROOT_CHK,
    ST_DN_RD,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### hdl/wfha_rank.sv
// ----------------------------------------------------------------------------
// Worst-fit heap allocator rank unit
// Shared comparator deciding whether one bin ranks strictly above another.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wfha_rank #(
  parameter int CW = 16,
  parameter int BW = 8
) (
  input  wire logic [CW-1:0] cap_a,
  input  wire logic [BW-1:0] bin_a,
  input  wire logic [CW-1:0] cap_b,
  input  wire logic [BW-1:0] bin_b,
  output logic               above
);
  always_comb begin
    if (cap_a != cap_b) begin
      above = cap_a > cap_b;
    end else begin
      above = bin_a < bin_b;
    end
  end
endmodule
`default_nettype wire

### hdl/worst_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// Worst-fit heap allocator
// Binary max-heap of bin capacities with worst-fit allocation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. in_func 0 appends a
// bin of capacity in_load_capacity and sifts it up; in_func 1 asks for
// in_group_size from the largest bin. Loads give no result, and a load into a
// full heap is dropped without raising busy. An allocation gives one result,
// marked by out_valid for one cycle, with out_accepted and out_bin_number.
// The receiver cannot stall; results are simply presented.
// Every bin-to-bin comparison goes through the single shared rank unit. A
// load reads the parent and compares at each level it climbs. An allocation
// reads the root and checks it against in_group_size, then at each level
// reads both children, selects the higher-ranked, and compares it with the
// moving bin. out_valid rises in the same cycle that busy falls. Reset
// clears the state, the bin count and out_valid; the stores need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module worst_fit_heap_allocator
  import wfha_pkg::*;
#(
  parameter int MAX_BINS  = 256,
  parameter int CAP_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [15:0] in_load_capacity,
  input  wire logic [15:0] in_group_size,
  output logic             out_valid,
  output logic             out_accepted,
  output logic [7:0]       out_bin_number
);
  localparam int AW = $clog2(MAX_BINS);
  localparam int NW = AW + 1;

  // Both stores are indexed by heap slot; a swap moves capacity and bin together.
  logic [CAP_WIDTH-1:0] cap_mem [MAX_BINS];
  logic [AW-1:0]        ord_mem [MAX_BINS];

  state_t state_r, state_nxt;
  logic [NW-1:0] count_r;
  logic [AW-1:0] slot_r, other_r;
  logic [AW-1:0] bin_a_r, bin_b_r, bin_c_r;
  logic [CAP_WIDTH-1:0] cap_a_r, cap_b_r, cap_c_r;
  logic          has_c_r;
  logic [15:0]   size_r;
  logic          valid_r, acc_r;
  logic [7:0]    num_r;

  logic          rank_above;
  logic [CAP_WIDTH-1:0] rk_cap_x, rk_cap_y;
  logic [AW-1:0] rk_bin_x, rk_bin_y;
  logic [NW:0]   child_l, child_r;

  wfha_rank #(.CW(CAP_WIDTH), .BW(AW)) u_rank (
    .cap_a(rk_cap_x), .bin_a(rk_bin_x), .cap_b(rk_cap_y), .bin_b(rk_bin_y),
    .above(rank_above));

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = valid_r;
  assign out_accepted   = acc_r;
  assign out_bin_number = num_r;

  assign child_l = {slot_r, 1'b1} + (NW+1)'(0);
  assign child_r = child_l + (NW+1)'(1);

  // Operand selection for the shared rank unit.
  always_comb begin
    unique case (state_r)
      ST_DN_SEL: begin
        rk_cap_x = cap_c_r;
        rk_bin_x = bin_c_r;
        rk_cap_y = cap_b_r;
        rk_bin_y = bin_b_r;
      end
      ST_DN_CMP: begin
        rk_cap_x = cap_b_r;
        rk_bin_x = bin_b_r;
        rk_cap_y = cap_a_r;
        rk_bin_y = bin_a_r;
      end
      default: begin
        rk_cap_x = cap_a_r;
        rk_bin_x = bin_a_r;
        rk_cap_y = cap_b_r;
        rk_bin_y = bin_b_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_func == FUNC_LOAD) begin
            state_nxt = (count_r < NW'(MAX_BINS)) ? ST_UP_RD : ST_IDLE;
          end else begin
            state_nxt = ST_ROOT_RD;
          end
        end
      end
      ST_UP_RD:    state_nxt = (slot_r == '0) ? ST_IDLE : ST_UP_CMP;
      ST_UP_CMP:   state_nxt = rank_above ? ST_UP_RD : ST_IDLE;
      ST_ROOT_RD:  state_nxt = (count_r == '0) ? ST_DONE : ST_ROOT_CHK;
      ST_ROOT_CHK: state_nxt = (16'(cap_a_r) < size_r) ? ST_DONE : ST_DN_RD;
      ST_DN_RD: begin
        state_nxt = ((NW+1)'(count_r) > child_l) ? ST_DN_SEL : ST_DONE;
      end
      ST_DN_SEL:   state_nxt = ST_DN_CMP;
      ST_DN_CMP:   state_nxt = rank_above ? ST_DN_RD : ST_DONE;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == ST_DONE);
      if (state_r == ST_IDLE && start && in_func == FUNC_LOAD &&
          count_r < NW'(MAX_BINS)) begin
        count_r <= count_r + NW'(1);
      end
    end
  end

  // Datapath: a holds the moving bin, b/c the partner(s) read this level.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        size_r <= in_group_size;
        acc_r  <= 1'b0;
        num_r  <= '0;
        if (start && in_func == FUNC_LOAD && count_r < NW'(MAX_BINS)) begin
          cap_mem[AW'(count_r)] <= CAP_WIDTH'(in_load_capacity);
          ord_mem[AW'(count_r)] <= AW'(count_r);
          slot_r  <= AW'(count_r);
          bin_a_r <= AW'(count_r);
          cap_a_r <= CAP_WIDTH'(in_load_capacity);
        end else begin
          slot_r <= '0;
        end
      end
      ST_UP_RD: begin
        other_r <= AW'((slot_r - AW'(1)) >> 1);
        bin_b_r <= ord_mem[AW'((slot_r - AW'(1)) >> 1)];
        cap_b_r <= cap_mem[AW'((slot_r - AW'(1)) >> 1)];
      end
      ST_UP_CMP: begin
        if (rank_above) begin
          ord_mem[slot_r]  <= bin_b_r;
          cap_mem[slot_r]  <= cap_b_r;
          ord_mem[other_r] <= bin_a_r;
          cap_mem[other_r] <= cap_a_r;
          slot_r <= other_r;
        end
      end
      ST_ROOT_RD: begin
        bin_a_r <= ord_mem[0];
        cap_a_r <= cap_mem[0];
      end
      ST_ROOT_CHK: begin
        if (!(16'(cap_a_r) < size_r)) begin
          cap_mem[0] <= cap_a_r - CAP_WIDTH'(size_r);
          cap_a_r <= cap_a_r - CAP_WIDTH'(size_r);
          acc_r   <= 1'b1;
          num_r   <= 8'(bin_a_r);
        end
      end
      ST_DN_RD: begin
        bin_b_r <= ord_mem[AW'(child_l)];
        cap_b_r <= cap_mem[AW'(child_l)];
        bin_c_r <= ord_mem[AW'(child_r)];
        cap_c_r <= cap_mem[AW'(child_r)];
        has_c_r <= (NW+1)'(count_r) > child_r;
      end
      ST_DN_SEL: begin
        if (has_c_r && rank_above) begin
          bin_b_r <= bin_c_r;
          cap_b_r <= cap_c_r;
          other_r <= AW'(child_r);
        end else begin
          other_r <= AW'(child_l);
        end
      end
      ST_DN_CMP: begin
        if (rank_above) begin
          ord_mem[slot_r]  <= bin_b_r;
          cap_mem[slot_r]  <= cap_b_r;
          ord_mem[other_r] <= bin_a_r;
          cap_mem[other_r] <= cap_a_r;
          slot_r <= other_r;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

### hdl/wfha_checker.sv
// ----------------------------------------------------------------------------
// Worst-fit heap allocator checker
// Port-level checks of the request and result timing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wfha_checker
  import wfha_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       in_func,
  input wire logic       out_valid,
  input wire logic       out_accepted,
  input wire logic [7:0] out_bin_number
);
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_LOAD |=> !out_valid)
    else $error("load gave a result");
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_REQUEST |=> busy)
    else $error("request not taken");
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_bin_number == 8'd0) else $error("bad reject");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
endmodule
bind worst_fit_heap_allocator wfha_checker u_wfha_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_func(in_func),
  .out_valid(out_valid), .out_accepted(out_accepted),
  .out_bin_number(out_bin_number));
`default_nettype wire
